FILE: src/jadzr_pkg.sv
package jadzr_pkg;

   localparam int unsigned DeadZoneWidth = 15;
   localparam int unsigned AxisWidth = 8;
   localparam int unsigned ValueWidth = 16;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned DivSteps = 16;
   localparam int unsigned StepCountWidth = 4;

   localparam logic [DeadZoneWidth-1:0] DeadZoneReset = 15'd2000;
   localparam logic [AxisWidth-1:0] TriggerAxisReset = 8'd7;
   localparam logic [AxisWidth-1:0] RightYAxisReset = 8'd3;
   localparam logic [AxisWidth-1:0] RightXAxisReset = 8'd2;
   localparam logic [AxisWidth-1:0] LeftYAxisReset = 8'd1;

   localparam logic [DeadZoneWidth-1:0] DeadZoneFull = 15'd32767;
   localparam logic signed [ValueWidth-1:0] ValueMax = 16'sh7FFF;
   localparam logic [ValueWidth-1:0] NegOffset = 16'h8000;

   typedef enum logic [2:0] {
      CSR_DEAD_ZONE     = 3'd0,
      CSR_TRIGGER_AXIS  = 3'd1,
      CSR_RIGHT_Y_AXIS  = 3'd2,
      CSR_RIGHT_X_AXIS  = 3'd3,
      CSR_LEFT_Y_AXIS   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [AxisWidth-1:0] axis_index;
      logic signed [ValueWidth-1:0] axis_value;
   } req_type;

   typedef struct packed {
      logic control_changed;
      logic signed [ValueWidth-1:0] trigger_out;
      logic signed [ValueWidth-1:0] right_x_out;
      logic signed [ValueWidth-1:0] right_y_out;
      logic left_y_active;
      logic signed [ValueWidth-1:0] left_y_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
      logic finish;
   } cmd_type;

endpackage

FILE: src/joystick_axis_dead_zone_rescaler.sv
// Each item taken by the input transfer passes through one setup state, 16 divider
// steps and a finish state that writes back and registers the result; the finish waits
// until the output register is free. The shared radix-2 divider holds one item at a time.
// The next item is taken while the previous result still waits in its register.
// Synchronous active-high reset clears the axis registers to 0 and loads the
// default dead zone and axis numbers.
module joystick_axis_dead_zone_rescaler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  jadzr_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output jadzr_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [jadzr_pkg::CsrDataWidth-1:0]  csr_data
);

   jadzr_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   jadzr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   jadzr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: src/jadzr_datapath.sv
module jadzr_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write,
   input  logic [2:0]                                csr_index,
   input  logic [jadzr_pkg::CsrDataWidth-1:0]        csr_data,
   input  jadzr_pkg::req_type                        req_payload,
   input  jadzr_pkg::cmd_type                        cmd,
   output jadzr_pkg::rsp_type                        rsp_payload
);

   typedef enum logic [1:0] {
      ROUTE_TRIGGER,
      ROUTE_RIGHT_Y,
      ROUTE_RIGHT_X,
      ROUTE_LEFT_Y
   } route_type;

   logic [jadzr_pkg::DeadZoneWidth-1:0] dead_zone_ff;
   logic [jadzr_pkg::AxisWidth-1:0] trigger_axis_ff;
   logic [jadzr_pkg::AxisWidth-1:0] right_y_axis_ff;
   logic [jadzr_pkg::AxisWidth-1:0] right_x_axis_ff;
   logic [jadzr_pkg::AxisWidth-1:0] left_y_axis_ff;

   logic signed [15:0] trigger_ff, trigger_in;
   logic signed [15:0] right_x_ff, right_x_in;
   logic signed [15:0] right_y_ff, right_y_in;
   logic signed [15:0] left_y_ff, left_y_in;

   jadzr_pkg::req_type event_ff;
   logic zero_ff, zero_in;
   logic special_ff, special_in;
   logic neg_ff;
   logic hit_ff, hit_in;
   route_type route_ff, route_in;
   logic [15:0] den_ff, den_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   jadzr_pkg::rsp_type rsp_ff, rsp_in;

   logic neg;
   logic [15:0] mag;
   logic [14:0] diff;
   logic [29:0] num;
   logic [16:0] trial;
   logic [15:0] result;
   logic changed;

   always_comb begin
      hit_in = 1'b1;
      route_in = ROUTE_LEFT_Y;
      if (event_ff.axis_index == trigger_axis_ff) begin
         route_in = ROUTE_TRIGGER;
      end else if (event_ff.axis_index == right_y_axis_ff) begin
         route_in = ROUTE_RIGHT_Y;
      end else if (event_ff.axis_index == right_x_axis_ff) begin
         route_in = ROUTE_RIGHT_X;
      end else if (event_ff.axis_index == left_y_axis_ff) begin
         route_in = ROUTE_LEFT_Y;
      end else begin
         hit_in = 1'b0;
      end
   end

   always_comb begin
      neg = event_ff.axis_value[15];
      mag = neg ? (16'd0 - event_ff.axis_value) : event_ff.axis_value;
      zero_in = mag < {1'b0, dead_zone_ff};
      special_in = !neg && (dead_zone_ff == jadzr_pkg::DeadZoneFull);
      diff = event_ff.axis_value[14:0] - dead_zone_ff;
      if (neg) begin
         num = {event_ff.axis_value[14:0], 15'd0};
         den_in = jadzr_pkg::NegOffset - {1'b0, dead_zone_ff};
      end else begin
         num = {diff, 15'd0} - {15'd0, diff};
         den_in = 16'h7FFF - {1'b0, dead_zone_ff};
      end
   end

   always_comb begin
      trial = {rem_ff, quo_ff[15]} - {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.setup) begin
         rem_in = {2'd0, num[29:16]};
         quo_in = num[15:0];
      end else if (cmd.step) begin
         rem_in = trial[16] ? {rem_ff[14:0], quo_ff[15]} : trial[15:0];
         quo_in = {quo_ff[14:0], !trial[16]};
      end
   end

   always_comb begin
      if (zero_ff) begin
         result = 16'd0;
      end else if (special_ff) begin
         result = jadzr_pkg::ValueMax;
      end else if (neg_ff) begin
         result = quo_ff + jadzr_pkg::NegOffset;
      end else begin
         result = quo_ff;
      end
      trigger_in = trigger_ff;
      right_x_in = right_x_ff;
      right_y_in = right_y_ff;
      left_y_in = left_y_ff;
      changed = 1'b0;
      if (hit_ff) begin
         case (route_ff)
            ROUTE_TRIGGER: begin
               trigger_in = result;
               changed = result != trigger_ff;
            end
            ROUTE_RIGHT_Y: begin
               right_y_in = result;
               changed = result != right_y_ff;
            end
            ROUTE_RIGHT_X: begin
               right_x_in = result;
               changed = result != right_x_ff;
            end
            default: begin
               left_y_in = result;
            end
         endcase
      end
      rsp_in.control_changed = changed;
      rsp_in.trigger_out = trigger_in;
      rsp_in.right_x_out = right_x_in;
      rsp_in.right_y_out = right_y_in;
      rsp_in.left_y_active = left_y_in != 16'sd0;
      rsp_in.left_y_out = left_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= jadzr_pkg::DeadZoneReset;
         trigger_axis_ff <= jadzr_pkg::TriggerAxisReset;
         right_y_axis_ff <= jadzr_pkg::RightYAxisReset;
         right_x_axis_ff <= jadzr_pkg::RightXAxisReset;
         left_y_axis_ff <= jadzr_pkg::LeftYAxisReset;
         trigger_ff <= 16'sd0;
         right_x_ff <= 16'sd0;
         right_y_ff <= 16'sd0;
         left_y_ff <= 16'sd0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               jadzr_pkg::CSR_DEAD_ZONE: begin
                  dead_zone_ff <= csr_data[jadzr_pkg::DeadZoneWidth-1:0];
               end
               jadzr_pkg::CSR_TRIGGER_AXIS: begin
                  trigger_axis_ff <= csr_data[jadzr_pkg::AxisWidth-1:0];
               end
               jadzr_pkg::CSR_RIGHT_Y_AXIS: begin
                  right_y_axis_ff <= csr_data[jadzr_pkg::AxisWidth-1:0];
               end
               jadzr_pkg::CSR_RIGHT_X_AXIS: begin
                  right_x_axis_ff <= csr_data[jadzr_pkg::AxisWidth-1:0];
               end
               jadzr_pkg::CSR_LEFT_Y_AXIS: begin
                  left_y_axis_ff <= csr_data[jadzr_pkg::AxisWidth-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.finish) begin
            trigger_ff <= trigger_in;
            right_x_ff <= right_x_in;
            right_y_ff <= right_y_in;
            left_y_ff <= left_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         event_ff <= req_payload;
      end
      if (cmd.setup) begin
         zero_ff <= zero_in;
         special_ff <= special_in;
         neg_ff <= neg;
         hit_ff <= hit_in;
         route_ff <= route_in;
         den_ff <= den_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: src/jadzr_control.sv
module jadzr_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jadzr_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      IDLE,
      SETUP,
      DIVIDE,
      FINISH
   } state_type;

   state_type state_ff;
   logic [jadzr_pkg::StepCountWidth-1:0] count_ff;
   logic req_ready_ff;
   logic rsp_valid_ff;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.load = req_valid && req_ready_ff;
      cmd.setup = state_ff == SETUP;
      cmd.step = state_ff == DIVIDE;
      cmd.finish = (state_ff == FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               req_ready_ff <= !req_valid || !req_ready_ff;
               if (req_valid && req_ready_ff) begin
                  state_ff <= SETUP;
               end
            end
            SETUP: begin
               count_ff <= '0;
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == jadzr_pkg::StepCountWidth'(jadzr_pkg::DivSteps - 1)) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  req_ready_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> state_ff == IDLE)
      else $error("input ready outside idle");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready_ff) |=> (state_ff == SETUP && !req_ready_ff))
      else $error("accepted transfer did not start work");
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");
   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE && count_ff == jadzr_pkg::StepCountWidth'(jadzr_pkg::DivSteps - 1))
      |=> state_ff == FINISH)
      else $error("divider did not end after its last step");
`endif

endmodule

FILE: tb/sv/tb_joystick_axis_dead_zone_rescaler.sv
module tb_joystick_axis_dead_zone_rescaler;
   import jadzr_pkg::*;

   localparam int StallLimit = 2000;
   localparam int ItemsPerSetting = 158;
   localparam int SettingsPerPhase = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   int send_idle = 0;
   int recv_idle = 0;
   int events_sent = 0;
   int csr_writes = 0;
   int settings_used = 0;
   int stall_cycles = 0;

   class axis_scoreboard;
      logic [DeadZoneWidth-1:0] dead_zone;
      logic [AxisWidth-1:0] trig_axis, ry_axis, rx_axis, ly_axis;
      logic signed [ValueWidth-1:0] trig_val, rx_val, ry_val, ly_val;
      rsp_type pending_outputs[$];
      int errors;
      int results_checked;

      function new();
         dead_zone = DeadZoneReset;
         trig_axis = TriggerAxisReset;
         ry_axis = RightYAxisReset;
         rx_axis = RightXAxisReset;
         ly_axis = LeftYAxisReset;
         trig_val = '0;
         rx_val = '0;
         ry_val = '0;
         ly_val = '0;
         errors = 0;
         results_checked = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_DEAD_ZONE: dead_zone = data[DeadZoneWidth-1:0];
            CSR_TRIGGER_AXIS: trig_axis = data[AxisWidth-1:0];
            CSR_RIGHT_Y_AXIS: ry_axis = data[AxisWidth-1:0];
            CSR_RIGHT_X_AXIS: rx_axis = data[AxisWidth-1:0];
            CSR_LEFT_Y_AXIS: ly_axis = data[AxisWidth-1:0];
            default: ;
         endcase
      endfunction

      // Both numerators are never negative, so truncating division is a floor.
      function logic signed [ValueWidth-1:0] rescale(logic signed [ValueWidth-1:0] v);
         longint sv;
         longint dz;
         longint mag;
         longint q;
         sv = v;
         dz = dead_zone;
         mag = (sv < 0) ? -sv : sv;
         if (mag < dz)
            q = 0;
         else if (sv < 0)
            q = -32768 + ((sv + 32768) * 32768) / (32768 - dz);
         else if (dz >= 32767)
            q = 32767;
         else
            q = ((sv - dz) * 32767) / (32767 - dz);
         return q[ValueWidth-1:0];
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         logic signed [ValueWidth-1:0] cond, old_t, old_x, old_y;
         cond = rescale(r.axis_value);
         old_t = trig_val;
         old_x = rx_val;
         old_y = ry_val;
         if (r.axis_index == trig_axis)
            trig_val = cond;
         else if (r.axis_index == ry_axis)
            ry_val = cond;
         else if (r.axis_index == rx_axis)
            rx_val = cond;
         else if (r.axis_index == ly_axis)
            ly_val = cond;
         e.control_changed = (trig_val != old_t) || (rx_val != old_x) || (ry_val != old_y);
         e.trigger_out = trig_val;
         e.right_x_out = rx_val;
         e.right_y_out = ry_val;
         e.left_y_active = (ly_val != 0);
         e.left_y_out = ly_val;
         pending_outputs.push_back(e);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         results_checked++;
         if (pending_outputs.size() == 0) begin
            $error("Result transfer arrived with no event waiting for it.");
            errors++;
            return;
         end
         e = pending_outputs.pop_front();
         compare_field("control_changed", e.control_changed, got.control_changed);
         compare_field("trigger_out", e.trigger_out, got.trigger_out);
         compare_field("right_x_out", e.right_x_out, got.right_x_out);
         compare_field("right_y_out", e.right_y_out, got.right_y_out);
         compare_field("left_y_active", e.left_y_active, got.left_y_active);
         compare_field("left_y_out", e.left_y_out, got.left_y_out);
      endfunction
   endclass

   axis_scoreboard sb = new();

   joystick_axis_dead_zone_rescaler u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_payload);
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= StallLimit) begin
               $display("Timeout: no transfer for %0d cycles.", StallLimit);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      events_sent++;
   endtask

   task automatic send_pair(input logic [AxisWidth-1:0] axis, input int value);
      req_type r;
      r.axis_index = axis;
      r.axis_value = 16'(value);
      send_item(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_outputs.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The unused upper data bits carry random values, which the block must ignore.
   task automatic apply_config(input logic [DeadZoneWidth-1:0] dz,
                               input logic [AxisWidth-1:0] trig, ry, rx, ly);
      wait_drained();
      write_csr(CSR_DEAD_ZONE, {1'($urandom), dz});
      write_csr(CSR_TRIGGER_AXIS, {8'($urandom), trig});
      write_csr(CSR_RIGHT_Y_AXIS, {8'($urandom), ry});
      write_csr(CSR_RIGHT_X_AXIS, {8'($urandom), rx});
      write_csr(CSR_LEFT_Y_AXIS, {8'($urandom), ly});
      settings_used++;
   endtask

   task automatic random_config();
      logic [DeadZoneWidth-1:0] dz;
      logic [AxisWidth-1:0] ax[4];
      case ($urandom_range(5))
         0: dz = '0;
         1: dz = DeadZoneFull;
         2: dz = 15'(DeadZoneFull - 1);
         3: dz = 15'($urandom_range(4000));
         default: dz = 15'($urandom);
      endcase
      foreach (ax[i])
         ax[i] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
      apply_config(dz, ax[0], ax[1], ax[2], ax[3]);
   endtask

   // Mostly routed axes, with values clustered around the band edges and the range ends.
   function automatic req_type make_item();
      req_type r;
      int pick;
      int b;
      case ($urandom_range(9))
         0, 1: r.axis_index = sb.trig_axis;
         2, 3: r.axis_index = sb.ry_axis;
         4, 5: r.axis_index = sb.rx_axis;
         6: r.axis_index = sb.ly_axis;
         default: r.axis_index = 8'($urandom);
      endcase
      pick = $urandom_range(9);
      if (pick < 4) begin
         b = $urandom_range(65535);
      end else if (pick < 7) begin
         b = int'(sb.dead_zone) + int'($urandom_range(6)) - 3;
         if (b < 0)
            b = 0;
         if (b > 32767)
            b = 32767;
         if ($urandom_range(1) == 1)
            b = -b;
      end else if (pick == 7) begin
         case ($urandom_range(3))
            0: b = 32767;
            1: b = -32768;
            2: b = -32767;
            default: b = 0;
         endcase
      end else begin
         b = $urandom_range(sb.dead_zone);
         if ($urandom_range(1) == 1)
            b = -b;
      end
      r.axis_value = 16'(b);
      return r;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle = 29;
      recv_idle = 55;

      // Reset settings: band edges, range ends, every routed axis and two unrouted ones.
      send_pair(7, 32767);
      send_pair(7, -32768);
      send_pair(7, 0);
      send_pair(7, 1999);
      send_pair(7, -2000);
      send_pair(3, 2000);
      send_pair(3, -1999);
      send_pair(2, 12345);
      send_pair(2, -32767);
      send_pair(1, -20000);
      send_pair(1, 500);
      send_pair(0, -1);
      send_pair(255, 16'h5555);

      // Zero band with every register on one axis: the trigger takes priority.
      apply_config(15'd0, 8'd9, 8'd9, 8'd9, 8'd9);
      send_pair(9, 0);
      send_pair(9, -1);
      send_pair(9, 1);

      // Full band with right y and right x sharing an axis.
      apply_config(DeadZoneFull, 8'd4, 8'd5, 8'd5, 8'd6);
      send_pair(5, 32767);
      send_pair(5, -32768);
      send_pair(5, 32766);
      send_pair(4, -32767);
      send_pair(6, 32767);

      apply_config(15'(DeadZoneFull - 1), 8'd4, 8'd5, 8'd255, 8'd6);
      send_pair(4, 32766);
      send_pair(4, -32766);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 29;
               recv_idle = 55;
            end
            1: begin
               send_idle = 55;
               recv_idle = 29;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         for (int s = 0; s < SettingsPerPhase; s++) begin
            random_config();
            repeat (ItemsPerSetting) send_item(make_item());
         end
      end

      wait_drained();
      if (sb.pending_outputs.size() != 0) begin
         $error("%0d expected results never arrived.", sb.pending_outputs.size());
         sb.errors += sb.pending_outputs.size();
      end
      $display("Summary: %0d axis events and %0d results checked under %0d settings.",
               events_sent, sb.results_checked, settings_used + 1);
      $display("Summary: %0d register writes, %0d mismatches.", csr_writes, sb.errors);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
src/jadzr_pkg.sv
src/jadzr_datapath.sv
src/jadzr_control.sv
src/joystick_axis_dead_zone_rescaler.sv
tb/sv/tb_joystick_axis_dead_zone_rescaler.sv
